### rtl/sfr_pkg.sv
// shared types, constants and helpers for the stream find-and-replace block
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = PATTERN_MAX * BYTE_W;
    localparam int LEN_W       = 4;
    localparam int POS_W       = 3;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic advance;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full_match;
        logic suffix_ok;
        logic emit_none;
        logic emit_last;
    } t_status;

    function automatic logic [BYTE_W-1:0] get_byte(input logic [WORD_W-1:0] word,
                                                  input logic [POS_W-1:0] k);
        get_byte = word[{k, 3'b000} +: BYTE_W];
    endfunction

endpackage

### rtl/sfr_ctrl.sv
// controller state machine: accept, suffix search, output beats
`timescale 1ns / 1ps

module sfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  sfr_pkg::t_status i_status,
    output sfr_pkg::t_cmd   o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.full_match || i_status.suffix_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_status.emit_none ? ST_IDLE : ST_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.advance = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);

endmodule

### rtl/sfr_datapath.sv
// datapath: config registers, match count, suffix compare lanes, output select
`timescale 1ns / 1ps

module sfr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic [sfr_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_in_end,
    input  sfr_pkg::t_cmd               i_cmd,
    output sfr_pkg::t_status            o_status,
    output logic [sfr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_run_last,
    output logic                        o_final_byte
);
    import sfr_pkg::*;

    logic [WORD_W-1:0] r_pat, r_rep;
    logic [LEN_W-1:0]  r_plen, r_rlen;
    logic [POS_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_c;
    logic              r_last;
    logic [POS_W-1:0]  r_m, n_m;
    logic [LEN_W-1:0]  r_s;
    logic [POS_W-1:0]  r_idx;

    logic [LEN_W-1:0]  plen_eff, rlen_eff, len, n_emit;
    logic [POS_W-1:0]  plen_m1;
    logic [PATTERN_MAX-1:0] lane_ok;
    logic              full;

    // clamp lengths
    always_comb begin
        if (r_plen == '0) begin
            plen_eff = LEN_W'(1);
        end else if (r_plen > LEN_W'(PATTERN_MAX)) begin
            plen_eff = LEN_W'(PATTERN_MAX);
        end else begin
            plen_eff = r_plen;
        end
        rlen_eff = (r_rlen > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : r_rlen;
    end

    assign plen_m1 = POS_W'(plen_eff - LEN_W'(1));
    assign n_m     = (r_count > plen_m1) ? plen_m1 : r_count;
    assign len     = {1'b0, r_m} + LEN_W'(1);
    assign full    = (len == plen_eff) && (r_c == get_byte(r_pat, r_m));

    // pending bytes are pattern bytes followed by the new byte
    function automatic logic [BYTE_W-1:0] buf_byte(input logic [POS_W-1:0] k,
                                                  input logic [POS_W-1:0] m,
                                                  input logic [BYTE_W-1:0] c,
                                                  input logic [WORD_W-1:0] pat);
        buf_byte = (k < m) ? get_byte(pat, k) : c;
    endfunction

    // one compare lane per pattern position for the current start
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_lane
        logic [LEN_W-1:0] pos;
        assign pos = r_s + LEN_W'(g);
        assign lane_ok[g] = (pos >= len) ||
            (buf_byte(pos[POS_W-1:0], r_m, r_c, r_pat) == get_byte(r_pat, POS_W'(g)));
    end

    assign n_emit = full ? rlen_eff : (r_last ? len : r_s);

    assign o_status.full_match = full;
    assign o_status.suffix_ok  = &lane_ok;
    assign o_status.emit_none  = (n_emit == '0);
    assign o_status.emit_last  = ({1'b0, r_idx} == n_emit - LEN_W'(1));

    assign o_out_byte   = full ? get_byte(r_rep, r_idx) : buf_byte(r_idx, r_m, r_c, r_pat);
    assign o_run_last   = o_status.emit_last;
    assign o_final_byte = o_status.emit_last & r_last;

    assign n_count = (full || r_last) ? '0 : POS_W'(len - r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat   <= '0;
            r_plen  <= LEN_W'(1);
            r_rep   <= '0;
            r_rlen  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PATTERN_BYTES:      r_pat  <= i_cfg_data;
                    CFG_PATTERN_LENGTH:     r_plen <= i_cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  r_rep  <= i_cfg_data;
                    CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_data[LEN_W-1:0];
                    default:                r_pat  <= r_pat;
                endcase
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c    <= i_in_byte;
            r_last <= i_in_end;
            r_m    <= n_m;
            r_s    <= '0;
        end else if (i_cmd.step) begin
            r_s    <= r_s + LEN_W'(1);
        end
        if (i_cmd.finish) begin
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + POS_W'(1);
        end
    end

endmodule

### rtl/stream_find_replace.sv
// top level of the streaming find-and-replace block
`timescale 1ns / 1ps
//
// Input stream (i_s_*): one source byte per beat, tlast marks the last byte of a stream.
// Output stream (o_m_*): one rewritten byte per beat; tuser is set on the last beat
// caused by an input byte, tlast on the very last beat of the stream.
// Config channel (i_cfg_*): index 0 pattern bytes, 1 pattern length, 2 replacement
// bytes, 3 replacement length; always ready, write only while no byte is in flight.
// One byte is handled at a time. An accepted byte is loaded, then a suffix search
// tries the candidate starts one after another (1 to 9 starts; a full match ends it
// at the first), then the byte yields 0 to 8 output beats.
// The output holds its beat while the receiver stalls, and no new byte is taken
// until every beat of the current one has been delivered.
// Synchronous reset clears the match count, sets pattern length 1, replacement
// length 0, and leaves the block ready for input.
//
module stream_find_replace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tlast,   // stream_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tuser,   // run_last
    output logic        o_m_tlast    // final_byte
);
    import sfr_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid)
    );

    sfr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_byte    (i_s_tdata),
        .i_in_end     (i_s_tlast),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_byte   (o_m_tdata),
        .o_run_last   (o_m_tuser),
        .o_final_byte (o_m_tlast)
    );

endmodule

### rtl/sfr_checker.sv
// port-level checker for the find-and-replace block and its bind
`timescale 1ns / 1ps

module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic       i_m_tuser,
    input logic       i_m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output beat changed while stalled");

    // input is never taken while beats are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_s_tready && i_m_tvalid))
        else $error("input ready while output pending");

    // an accepted byte blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after accept");

    // end of stream beat also ends its run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tuser)
        else $error("final beat without run end");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);
